// ----- src/b64d_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package b64d_pkg;

    // Longest string, in characters, that is decoded and counted
    localparam int MAX_CHARS = 4096;
    localparam int CNT_W     = $clog2(MAX_CHARS + 1);
    localparam int GRP_W     = CNT_W - 2;
    localparam int CAP_W     = 16;
    // Wide enough for groups*3+1 and for the capacity register
    localparam int CMP_W     = (CNT_W + 2 > CAP_W) ? CNT_W + 2 : CAP_W;

    localparam logic [CAP_W-1:0] CAP_RESET = 16'hFFFF;

    localparam logic [7:0] CHAR_PAD   = 8'h3D;
    localparam logic [7:0] CHAR_UP_A  = 8'h41;
    localparam logic [7:0] CHAR_UP_Z  = 8'h5A;
    localparam logic [7:0] CHAR_LO_A  = 8'h61;
    localparam logic [7:0] CHAR_LO_Z  = 8'h7A;
    localparam logic [7:0] CHAR_DIG_0 = 8'h30;
    localparam logic [7:0] CHAR_DIG_9 = 8'h39;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;

    localparam logic [5:0] SEXT_LO_BASE  = 6'd26;
    localparam logic [5:0] SEXT_DIG_BASE = 6'd52;
    localparam logic [5:0] SEXT_PLUS     = 6'd62;
    localparam logic [5:0] SEXT_SLASH    = 6'd63;

    localparam logic [7:0] MASK_HI4 = 8'hF0;
    localparam logic [7:0] MASK_HI2 = 8'hC0;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_LEN     = 3'd1;
    localparam logic [2:0] ST_ASCII   = 3'd2;
    localparam logic [2:0] ST_INVALID = 3'd3;
    localparam logic [2:0] ST_PAD     = 3'd4;

    typedef struct packed {
        logic [7:0] char_code;
        logic       is_last;
    } t_in_item;

    typedef struct packed {
        logic       byte_valid;
        logic [7:0] data_byte;
        logic       done_res;
        logic [2:0] status;
    } t_out_item;

    typedef struct packed {
        logic       valid;
        logic [5:0] value;
    } t_sextet;

endpackage

`default_nettype wire

// ----- src/b64d_sextet_lut.sv -----
`timescale 1ns / 1ps
`default_nettype none

module b64d_sextet_lut (
    input  wire logic [7:0]       i_char,
    output b64d_pkg::t_sextet     o_sextet
);

    logic [7:0] w_ofs_up;
    logic [7:0] w_ofs_lo;
    logic [7:0] w_ofs_dig;

    assign w_ofs_up  = i_char - b64d_pkg::CHAR_UP_A;
    assign w_ofs_lo  = i_char - b64d_pkg::CHAR_LO_A;
    assign w_ofs_dig = i_char - b64d_pkg::CHAR_DIG_0;

    always_comb begin
        o_sextet.valid = 1'b1;
        o_sextet.value = '0;
        if (i_char >= b64d_pkg::CHAR_UP_A && i_char <= b64d_pkg::CHAR_UP_Z) begin
            o_sextet.value = w_ofs_up[5:0];
        end else if (i_char >= b64d_pkg::CHAR_LO_A && i_char <= b64d_pkg::CHAR_LO_Z) begin
            o_sextet.value = w_ofs_lo[5:0] + b64d_pkg::SEXT_LO_BASE;
        end else if (i_char >= b64d_pkg::CHAR_DIG_0 && i_char <= b64d_pkg::CHAR_DIG_9) begin
            o_sextet.value = w_ofs_dig[5:0] + b64d_pkg::SEXT_DIG_BASE;
        end else if (i_char == b64d_pkg::CHAR_PLUS) begin
            o_sextet.value = b64d_pkg::SEXT_PLUS;
        end else if (i_char == b64d_pkg::CHAR_SLASH) begin
            o_sextet.value = b64d_pkg::SEXT_SLASH;
        end else begin
            o_sextet.valid = 1'b0;
        end
    end

endmodule

`default_nettype wire

// ----- src/b64d_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

module b64d_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_fire,
    input  wire b64d_pkg::t_in_item            i_item,
    input  wire logic [b64d_pkg::CAP_W-1:0]    i_capacity,
    output b64d_pkg::t_out_item                o_result
);

    logic [b64d_pkg::CNT_W-1:0] r_count, n_count;
    logic                       r_ovf, n_ovf;
    logic [5:0]                 r_prev, n_prev;
    logic                       r_pad, n_pad;
    logic                       r_open, n_open;
    logic [2:0]                 r_gerr, n_gerr;
    logic                       r_nas, n_nas;

    b64d_pkg::t_sextet w_sext;

    logic [1:0]                 w_pos;
    logic                       w_quiet;
    logic [2:0]                 w_new_err;
    logic [b64d_pkg::GRP_W-1:0] w_groups;
    logic [b64d_pkg::CMP_W-1:0] w_need;
    logic [7:0]                 w_byte;
    logic                       w_valid;

    b64d_sextet_lut u_lut (
        .i_char   (i_item.char_code),
        .o_sextet (w_sext)
    );

    assign w_pos = r_count[1:0];

    always_comb begin
        n_count   = r_count;
        n_ovf     = r_ovf;
        n_prev    = r_prev;
        n_pad     = r_pad;
        n_open    = r_open;
        n_nas     = r_nas | i_item.char_code[7];
        w_new_err = b64d_pkg::ST_OK;
        w_byte    = '0;
        w_valid   = 1'b0;
        w_quiet   = (r_gerr != b64d_pkg::ST_OK) || n_nas;

        if (r_count >= b64d_pkg::CNT_W'(b64d_pkg::MAX_CHARS)) begin
            n_ovf = 1'b1;
        end else begin
            n_count = r_count + 1'b1;
            if (r_open) begin
                n_open = 1'b0;
                if (i_item.char_code != b64d_pkg::CHAR_PAD) begin
                    w_new_err = w_sext.valid ? b64d_pkg::ST_PAD : b64d_pkg::ST_INVALID;
                end
            end else if (r_pad) begin
                w_new_err = b64d_pkg::ST_PAD;
            end else if (i_item.char_code == b64d_pkg::CHAR_PAD && w_pos[1]) begin
                n_pad = 1'b1;
                if (w_pos == 2'd2) begin
                    n_open = 1'b1;
                end
            end else if (!w_sext.valid) begin
                w_new_err = b64d_pkg::ST_INVALID;
            end else begin
                case (w_pos)
                    2'd1: w_byte = {r_prev, w_sext.value[5:4]};
                    2'd2: w_byte = ({r_prev[3:0], 4'b0000} & b64d_pkg::MASK_HI4)
                                   | {4'b0000, w_sext.value[5:2]};
                    2'd3: w_byte = ({r_prev[1:0], 6'b000000} & b64d_pkg::MASK_HI2)
                                   | {2'b00, w_sext.value};
                    default: w_byte = '0;
                endcase
                w_valid = (w_pos != 2'd0) && !w_quiet;
                n_prev  = w_sext.value;
            end
        end

        // keep the first error of the stream
        n_gerr = (r_gerr == b64d_pkg::ST_OK) ? w_new_err : r_gerr;

        w_groups = n_count[b64d_pkg::CNT_W-1:2];
        w_need   = b64d_pkg::CMP_W'({w_groups, 1'b0}) + b64d_pkg::CMP_W'(w_groups)
                   + b64d_pkg::CMP_W'(1);

        o_result.byte_valid = w_valid;
        o_result.data_byte  = w_valid ? w_byte : 8'h00;
        o_result.done_res   = i_item.is_last;
        o_result.status     = b64d_pkg::ST_OK;

        if (i_item.is_last) begin
            if (n_ovf || (n_count[1:0] != 2'd0)
                    || (w_need > b64d_pkg::CMP_W'(i_capacity))) begin
                o_result.status = b64d_pkg::ST_LEN;
            end else if (n_nas) begin
                o_result.status = b64d_pkg::ST_ASCII;
            end else begin
                o_result.status = n_gerr;
            end
            // clear the stream for the next string
            n_count = '0;
            n_ovf   = 1'b0;
            n_prev  = '0;
            n_pad   = 1'b0;
            n_open  = 1'b0;
            n_gerr  = b64d_pkg::ST_OK;
            n_nas   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_prev  <= '0;
            r_pad   <= 1'b0;
            r_open  <= 1'b0;
            r_gerr  <= b64d_pkg::ST_OK;
            r_nas   <= 1'b0;
        end else if (i_fire) begin
            r_count <= n_count;
            r_ovf   <= n_ovf;
            r_prev  <= n_prev;
            r_pad   <= n_pad;
            r_open  <= n_open;
            r_gerr  <= n_gerr;
            r_nas   <= n_nas;
        end
    end

endmodule

`default_nettype wire

// ----- src/base64_decoder_checked_top.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Each character is held in the input register, then decoded, and the stream-state
// update writes its result into the result register.
// Throughput: one character per cycle while the result register is free or read;
// each updates the stream state (count, previous sextet, padding and error flags).
// Reset (synchronous, active low): stream state cleared, both stages empty,
// r_capacity set to 65535.
module base64_decoder_checked_top (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire b64d_pkg::t_in_item          i_in_data,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output b64d_pkg::t_out_item              o_out_data,
    input  wire logic                        i_cfg_we,
    input  wire logic [b64d_pkg::CAP_W-1:0]  i_cfg_wdata
);

    logic                       r_in_valid;
    b64d_pkg::t_in_item         r_in;
    logic                       r_out_valid;
    b64d_pkg::t_out_item        r_out;
    logic [b64d_pkg::CAP_W-1:0] r_capacity;

    logic                w_process;
    b64d_pkg::t_out_item w_result;

    // advance the held character when the result register is free or being read
    assign w_process  = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_process;

    b64d_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (w_process),
        .i_item     (r_in),
        .i_capacity (r_capacity),
        .o_result   (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_capacity  <= b64d_pkg::CAP_RESET;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_process) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                r_capacity <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_data;
        end
        if (w_process) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // a held character that cannot advance stays put
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_process) |=> (r_in_valid && $stable(r_in)))
        else $error("input stage lost or changed a waiting transaction");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_process |=> o_out_valid)
        else $error("processed transaction did not reach the result register");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.done_res) |-> (o_out_data.status == b64d_pkg::ST_OK))
        else $error("status reported before the last character");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_process && r_in.char_code[7]) |-> !w_result.byte_valid)
        else $error("byte given for a non-ASCII character");

endmodule

`default_nettype wire
